// ===== hw/rtl/fpsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types and codes for the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [ADDR_W-1:0]    word_t;
  typedef logic [1:0]           cmd_t;
  typedef logic [1:0]           status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Commands
  localparam cmd_t CMD_INIT  = 2'd0;
  localparam cmd_t CMD_ALLOC = 2'd1;
  localparam cmd_t CMD_FREE  = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  // Status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_BADFREE = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  // Register indexes
  localparam cfg_idx_t REG_HEAP_START = 1'd0;
  localparam cfg_idx_t REG_MEM_STOP   = 1'd1;

  localparam word_t HEAP_START_RST = 32'h8000_0000;
  localparam word_t MEM_STOP_RST   = 32'h8800_0000;

endpackage
`default_nettype wire

// ===== hw/rtl/fpsa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_if
// Valid/ready channels: requests, results and register writes.
// ----------------------------------------------------------------------------
interface fpsa_req_if import fpsa_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t page_address;

  modport source (output valid, output command, output page_address, input ready);
  modport sink   (input valid, input command, input page_address, output ready);
endinterface

interface fpsa_rsp_if import fpsa_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   granted_address;
  status_t status;

  modport source (output valid, output granted_address, output status, input ready);
  modport sink   (input valid, input granted_address, input status, output ready);
endinterface

interface fpsa_cfg_if import fpsa_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpsa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module fpsa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/free_page_stack_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_page_stack_allocator
// LIFO stack of free physical page numbers kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Timing: free, bad free, no-op and empty alloc answer at the accept edge;
//   a pop reads the stack RAM, then answers from S_ALLOC; init writes one
//   pushed page per cycle, then answers; a pop holds off requests meanwhile.
// Throughput: free/no-op/empty alloc one per cycle while results are taken.
// Reset (synchronous): stack count to zero, registers to their reset values,
//   controller idle, no result pending. Stack RAM is not cleared.
// ----------------------------------------------------------------------------
module free_page_stack_allocator import fpsa_pkg::*; #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input wire logic clk,
  input wire logic rst,
  fpsa_cfg_if.sink   cfg,
  fpsa_req_if.sink   req,
  fpsa_rsp_if.source rsp
);

  // Page number width, stack RAM address width, count width (0..MAX_PAGES)
  localparam int PN_W  = ADDR_W - PAGE_SHIFT;
  localparam int AW    = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAGES);
  localparam word_t PG_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  // Controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_INIT  = 2'd2;

  // Configuration registers
  word_t heap_start;
  word_t mem_stop;

  // Control state
  logic [1:0]      state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PN_W:0]   pg, pg_next;      // init cursor, one spare bit for wrap
  logic            out_valid, out_valid_next;

  // Result payload
  word_t   out_addr, out_addr_next;
  status_t out_status, out_status_next;
  logic    load_out;

  // Stack RAM port
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [PN_W-1:0] ram_wdata, ram_rdata;

  // Derived values
  logic [ADDR_W:0] start_sum;
  logic [PN_W:0]   start_pg, stop_pg;
  logic            req_fire, stack_full, free_bad;
  logic [CNT_W-1:0] count_dec;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= HEAP_START_RST;
      mem_stop   <= MEM_STOP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HEAP_START: heap_start <= cfg.data;
        REG_MEM_STOP:   mem_stop   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Accept only when idle and the result slot is empty or frees up this edge
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid           = out_valid;
  assign rsp.granted_address = out_addr;
  assign rsp.status          = out_status;

  // Init range in page numbers: first page is heap_start rounded up,
  // last pushed page is the one that ends at or before mem_stop.
  assign start_sum = {1'b0, heap_start} + {1'b0, PG_MASK};
  assign start_pg  = start_sum[ADDR_W:PAGE_SHIFT];
  assign stop_pg   = {1'b0, mem_stop[ADDR_W-1:PAGE_SHIFT]};

  assign stack_full = (count == CNT_MAX);
  assign count_dec  = count - CNT_W'(1);
  assign free_bad   = (req.page_address[PAGE_SHIFT-1:0] != '0)
                   || (req.page_address < heap_start)
                   || (req.page_address >= mem_stop);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pg_next         = pg;
    out_valid_next  = out_valid && !rsp.ready;
    load_out        = 1'b0;
    out_addr_next   = '0;
    out_status_next = ST_OK;
    ram_we          = 1'b0;
    ram_waddr       = count[AW-1:0];
    ram_wdata       = req.page_address[ADDR_W-1:PAGE_SHIFT];
    ram_re          = 1'b0;
    ram_raddr       = count_dec[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req.command)
            CMD_INIT: begin
              pg_next    = start_pg;
              state_next = S_INIT;
            end
            CMD_ALLOC: begin
              if (count == '0) begin
                load_out        = 1'b1;
                out_status_next = ST_EMPTY;
              end else begin
                // pop: read top entry; the result is loaded from it in S_ALLOC
                ram_re     = 1'b1;
                count_next = count_dec;
                state_next = S_ALLOC;
              end
            end
            CMD_FREE: begin
              load_out = 1'b1;
              if (free_bad) begin
                out_status_next = ST_BADFREE;
              end else if (stack_full) begin
                out_status_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            default: begin
              load_out = 1'b1;  // no-op
            end
          endcase
        end
      end
      S_ALLOC: begin
        load_out      = 1'b1;
        out_addr_next = {ram_rdata, {PAGE_SHIFT{1'b0}}};
        state_next    = S_IDLE;
      end
      S_INIT: begin
        ram_wdata = pg[PN_W-1:0];
        if (pg >= stop_pg) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end else if (stack_full) begin
          // remaining pages would overflow as well
          load_out        = 1'b1;
          out_status_next = ST_FULL;
          state_next      = S_IDLE;
        end else begin
          ram_we     = 1'b1;
          count_next = count + CNT_W'(1);
          pg_next    = pg + (PN_W+1)'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pg <= pg_next;
    if (load_out) begin
      out_addr   <= out_addr_next;
      out_status <= out_status_next;
    end
  end

  fpsa_ram #(
    .WIDTH (PN_W),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free page stack allocator. A shadow stack of
// page numbers predicts each result; a monitor compares results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fpsa_pkg::*;

  localparam int MAX_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam longint unsigned PG = 64'd1 << PAGE_SHIFT;
  localparam word_t PAGE_BYTES = word_t'(PG);
  localparam word_t OFS_MASK   = word_t'(PG - 1);
  // Worst legal run is dominated by the full-stack init in test_full_stack
  // plus ~2k requests with stalls on both sides.
  localparam int unsigned LIMIT = 1_000_000;

  typedef logic [ADDR_W-PAGE_SHIFT-1:0] pnum_t;
  typedef struct packed {
    word_t   granted;
    status_t status;
  } page_result_t;

  logic clk;
  logic rst;

  fpsa_cfg_if cfg_ch();
  fpsa_req_if req_ch();
  fpsa_rsp_if rsp_ch();

  free_page_stack_allocator #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the allocator: stack, depth and both range registers.
  pnum_t        shadow_pages [MAX_PAGES];
  int unsigned  shadow_depth;
  word_t        shadow_heap;
  word_t        shadow_stop;

  page_result_t pending_results[$];  // predicted, not yet seen on rsp
  word_t        loaned_pages[$];     // recently granted, candidates to free

  int unsigned  err_cnt;
  int unsigned  cycle_cnt;
  int unsigned  hold_left;           // rsp hold-off, counted by ready driver
  bit           no_stall;            // both sides run without idling

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic page_result_t predict_page_result(cmd_t c, word_t a);
    page_result_t    r;
    longint unsigned pa;
    r.granted = '0;
    r.status  = ST_OK;
    case (c)
      CMD_INIT: begin
        // round heap start up in 64 bits so a start near the top gives
        // an empty range instead of wrapping to zero
        pa = {32'd0, shadow_heap};
        pa = (pa + PG - 1) & ~(PG - 1);
        while (pa + PG <= {32'd0, shadow_stop} && r.status == ST_OK) begin
          if (shadow_depth >= MAX_PAGES) begin
            r.status = ST_FULL;  // rest of the range is dropped
          end else begin
            shadow_pages[shadow_depth] = pnum_t'(pa >> PAGE_SHIFT);
            shadow_depth++;
            pa += PG;
          end
        end
      end
      CMD_ALLOC: begin
        if (shadow_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_depth--;
          r.granted = {shadow_pages[shadow_depth], {PAGE_SHIFT{1'b0}}};
          loaned_pages.push_back(r.granted);
          if (loaned_pages.size() > 64) void'(loaned_pages.pop_front());
        end
      end
      CMD_FREE: begin
        // range check wins over the full check; double free is not caught
        if ((a & OFS_MASK) != '0 || a < shadow_heap || a >= shadow_stop) begin
          r.status = ST_BADFREE;
        end else if (shadow_depth >= MAX_PAGES) begin
          r.status = ST_FULL;
        end else begin
          shadow_pages[shadow_depth] = pnum_t'(a >> PAGE_SHIFT);
          shadow_depth++;
        end
      end
      default: ;  // the no-op command: plain no-op result
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: request accepted -> predict; result accepted -> compare.
  // Prediction runs first so a same-edge result still finds its entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    page_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        pending_results.push_back(predict_page_result(req_ch.command, req_ch.page_address));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", rsp_ch.granted_address, '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.granted_address !== want.granted)
            report_mismatch("granted_address", rsp_ch.granted_address, want.granted);
          if (rsp_ch.status !== want.status)
            report_mismatch("status", word_t'(rsp_ch.status), word_t'(want.status));
        end
      end
    end
  end

  // Result ready: random idling, a counted hold-off, or always on.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (no_stall) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
                 pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one request and return after the edge that accepts it. valid is
  // only lowered on an idle cycle, so back-to-back requests keep it high.
  task automatic send_request(cmd_t c, word_t a);
    if (!no_stall) begin
      while ($urandom_range(99) < 17) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= c;
    req_ch.page_address <= a;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop offering, let every pending result drain, then pad with spare cycles.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both range registers back to back; only called while idle.
  task automatic write_regs(word_t heap, word_t stop);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_HEAP_START;
    cfg_ch.data  <= heap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_heap = heap;
    cfg_ch.index <= REG_MEM_STOP;
    cfg_ch.data  <= stop;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_stop = stop;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Address pickers
  // --------------------------------------------------------------------------
  // Aligned page inside [heap, stop): a free that should be taken (any aligned page if none).
  function automatic word_t pick_heap_page();
    longint unsigned lo, hi, n;
    lo = {32'd0, shadow_heap};
    lo = (lo + PG - 1) & ~(PG - 1);
    hi = {32'd0, shadow_stop - 1'b1} & ~(PG - 1);
    if (shadow_stop == '0 || lo > hi) return $urandom & ~OFS_MASK;
    n = $urandom_range(32'((hi - lo) >> PAGE_SHIFT), 0);
    return word_t'(lo + (n << PAGE_SHIFT));
  endfunction

  // Addresses right at or next to the range edges, or misaligned inside it.
  function automatic word_t pick_edge_address();
    case ($urandom_range(7))
      0: return shadow_heap;
      1: return shadow_heap & ~OFS_MASK;
      2: return (shadow_heap & ~OFS_MASK) - PAGE_BYTES;
      3: return shadow_stop;
      4: return shadow_stop & ~OFS_MASK;
      5: return (shadow_stop - 1'b1) & ~OFS_MASK;
      6: return pick_heap_page() | word_t'($urandom_range(32'(PG - 1), 1));
      default: return (shadow_stop & ~OFS_MASK) - PAGE_BYTES;
    endcase
  endfunction

  // Random small range; a few cases hit the address space edges or invert.
  task automatic pick_range(output word_t heap, output word_t stop);
    longint unsigned top;
    int unsigned     np;
    np = $urandom_range(24);
    case ($urandom_range(9))
      0: begin
        heap = '0;
        top  = np * PG + $urandom_range(32'(PG - 1));
      end
      1: begin
        heap = word_t'(64'h1_0000_0000 - (np + 1) * PG);
        if ($urandom_range(1)) heap = heap | word_t'($urandom_range(32'(PG - 1)));
        top  = 64'hFFFF_FFFF;
      end
      2: begin
        heap = $urandom;
        top  = $urandom_range(heap);  // stop at or below start
      end
      default: begin
        heap = $urandom & ~OFS_MASK;
        if ($urandom_range(3) == 0) heap = heap | word_t'($urandom_range(32'(PG - 1), 1));
        top = {32'd0, heap};
        top = ((top + PG - 1) & ~(PG - 1)) + np * PG;
        if ($urandom_range(1)) top += $urandom_range(32'(PG - 1));
      end
    endcase
    stop = (top > 64'hFFFF_FFFF) ? '1 : word_t'(top);
  endtask

  // Mostly legal traffic with random content, the rest edges and noise.
  task automatic run_mixed(int unsigned n, int unsigned alloc_pct);
    int unsigned roll;
    word_t       a;
    repeat (n) begin
      a = $urandom;
      if ($urandom_range(99) < alloc_pct) begin
        send_request(CMD_ALLOC, a);
      end else begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          send_request(CMD_FREE, pick_heap_page());
        end else if (roll < 50) begin
          if (loaned_pages.size() != 0) a = loaned_pages.pop_front();
          else a = pick_heap_page();
          send_request(CMD_FREE, a);
        end else if (roll < 60) begin
          send_request(CMD_INIT, a);
        end else if (roll < 80) begin
          send_request(CMD_FREE, pick_edge_address());
        end else if (roll < 92) begin
          send_request(CMD_FREE, a);
        end else begin
          send_request(CMD_NOP, a);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset range via frees only; an init here would fill the whole stack.
  task automatic test_reset_values();
    send_request(CMD_ALLOC, '1);                              // empty stack
    send_request(CMD_NOP, '1);
    send_request(CMD_FREE, HEAP_START_RST);                   // lowest page
    send_request(CMD_FREE, HEAP_START_RST - PAGE_BYTES);      // just below
    send_request(CMD_FREE, MEM_STOP_RST);                     // at stop
    send_request(CMD_FREE, HEAP_START_RST + (PAGE_BYTES >> 1)); // misaligned
    send_request(CMD_FREE, MEM_STOP_RST - PAGE_BYTES);        // highest page
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '1);                              // empty again
  endtask

  task automatic test_directed_ranges();
    // unaligned start rounds up; stop cuts a partial page
    wait_idle();
    write_regs(32'h0000_0001, 32'h0000_5800);
    send_request(CMD_INIT, '0);
    send_request(CMD_INIT, '1);                // stacks on top of the first
    send_request(CMD_FREE, 32'h0000_0000);     // below unaligned start
    send_request(CMD_FREE, 32'h0000_5000);     // partial page is freeable
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    // start at the very top: rounding leaves nothing
    wait_idle();
    write_regs('1, '1);
    send_request(CMD_INIT, '0);
    send_request(CMD_FREE, 32'hFFFF_F000);
    // one page below the top; top page only reachable by free
    wait_idle();
    write_regs(32'hFFFF_E000, '1);
    send_request(CMD_INIT, '0);
    send_request(CMD_FREE, 32'hFFFF_F000);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    // inverted range
    wait_idle();
    write_regs(32'h0001_0000, '0);
    send_request(CMD_INIT, '0);
    send_request(CMD_FREE, 32'h0001_0000);
  endtask

  task automatic test_random_mix();
    word_t heap, stop;
    for (int p = 0; p < 14; p++) begin
      wait_idle();
      pick_range(heap, stop);
      write_regs(heap, stop);
      no_stall = (p == 6);  // one long stretch with no idling
      run_mixed(130, 42);
      no_stall = 1'b0;
    end
  endtask

  // Results held off while requests keep coming: input must stall, then
  // the sender stops until every result is back.
  task automatic test_backpressure();
    wait_idle();
    write_regs(32'h4000_0000, 32'h4001_0000);
    send_request(CMD_INIT, '0);
    hold_left = 300;
    no_stall  = 1'b1;
    run_mixed(40, 40);
    no_stall  = 1'b0;
    wait_idle();
    run_mixed(20, 40);
  endtask

  // Left for last: once full, the stack is only drained by allocs.
  task automatic test_full_stack();
    wait_idle();
    write_regs(HEAP_START_RST, MEM_STOP_RST);
    send_request(CMD_INIT, '0);                       // fill to the top
    send_request(CMD_FREE, HEAP_START_RST);           // valid, but full
    send_request(CMD_FREE, MEM_STOP_RST);             // bad beats full
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, HEAP_START_RST);           // fits again
    send_request(CMD_ALLOC, '0);
    send_request(CMD_INIT, '0);                       // one fits, rest dropped
    run_mixed(80, 25);
    // widest range: overflow after a handful of pushes
    wait_idle();
    write_regs('0, '1);
    repeat (3) send_request(CMD_ALLOC, $urandom);
    send_request(CMD_INIT, '0);
    send_request(CMD_FREE, 32'hFFFF_F000);
    send_request(CMD_ALLOC, '1);
    run_mixed(40, 30);
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_NOP;
    req_ch.page_address <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_HEAP_START;
    cfg_ch.data         <= '0;
    shadow_depth = 0;
    shadow_heap  = HEAP_START_RST;
    shadow_stop  = MEM_STOP_RST;
    err_cnt      = 0;
    hold_left    = 0;
    no_stall     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_ranges();
    test_random_mix();
    test_backpressure();
    test_full_stack();

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
